// File: sv/bsmm_pkg.sv
// Package for the block-sparse mask multiplier.
// Holds sizes, item and state structs and the rounded-product function.
// No dependencies; every other file uses it by scoped names.
package bsmm_pkg;

	localparam int ELEMS_PER_BLOCK = 4096;
	localparam int DATA_DEPTH = 1048576;

	localparam int IDX_W = (ELEMS_PER_BLOCK > 1) ? $clog2(ELEMS_PER_BLOCK) : 1;
	localparam int CNT_W = $clog2(DATA_DEPTH + 1);
	localparam int SUM_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

	typedef struct packed {
		logic       first_of_mask;
		logic       a_uniform;
		logic [7:0] a_value;
		logic       b_uniform;
		logic [7:0] b_value;
		logic       last_in_block;
	} bsmm_in_t;

	typedef struct packed {
		logic [7:0]  product;
		logic        data_write;
		logic [19:0] data_address;
		logic        block_done;
		logic        block_dense;
		logic [7:0]  block_scalar;
		logic [19:0] block_start;
		logic [20:0] data_total;
		logic        data_full;
	} bsmm_out_t;

	typedef struct packed {
		logic [CNT_W-1:0] committed_bytes;
		logic [IDX_W-1:0] element_index;
		logic             all_equal_so_far;
		logic [7:0]       first_product;
		logic             overflow_seen;
	} bsmm_state_t;

	// (a*b + 127) / 255, divide done as (x + (x >> 8) + 1) >> 8, exact below 65536
	function automatic logic [7:0] rounded_product(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] p;
		logic [16:0] x;
		logic [16:0] s;
		p = a * b;
		x = {1'b0, p} + 17'd127;
		s = x + {8'd0, x[16:8]} + 17'd1;
		return s[15:8];
	endfunction

endpackage

// File: sv/bsmm_in_if.sv
// Element channel: valid/ready handshake carrying one input item.
// Depends on bsmm_pkg for the payload type.
interface bsmm_in_if;
	logic               valid;
	logic               ready;
	bsmm_pkg::bsmm_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/bsmm_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on bsmm_pkg for the payload type.
interface bsmm_out_if;
	logic                valid;
	logic                ready;
	bsmm_pkg::bsmm_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/bsmm_calc.sv
// Per-element datapath: product, data write, block classification, next state.
// Purely combinational; depends on bsmm_pkg.
module bsmm_calc (
	input  bsmm_pkg::bsmm_in_t    item,
	input  bsmm_pkg::bsmm_state_t cur,
	output bsmm_pkg::bsmm_out_t   res,
	output bsmm_pkg::bsmm_state_t nxt
);

	logic [7:0]                    prod;
	logic [bsmm_pkg::CNT_W-1:0]    cb;
	logic [bsmm_pkg::IDX_W-1:0]    idx;
	logic                          ovf;
	logic                          alleq;
	logic [7:0]                    first;
	logic                          skip;
	logic                          last;
	logic [bsmm_pkg::SUM_W-1:0]    addr_sum;
	logic                          fits;
	logic [bsmm_pkg::CNT_W-1:0]    room;
	logic [bsmm_pkg::SUM_W-1:0]    ext;
	logic [bsmm_pkg::SUM_W-1:0]    grow;
	logic [31:0]                   addr32;
	logic [31:0]                   cb32;
	logic [31:0]                   tot32;

	assign prod = bsmm_pkg::rounded_product(item.a_value, item.b_value);

	always_comb begin
		cb    = item.first_of_mask ? '0 : cur.committed_bytes;
		idx   = item.first_of_mask ? '0 : cur.element_index;
		ovf   = item.first_of_mask ? 1'b0 : cur.overflow_seen;
		alleq = item.first_of_mask ? 1'b1 : cur.all_equal_so_far;
		first = item.first_of_mask ? 8'd0 : cur.first_product;

		skip = (item.a_uniform && item.b_uniform) ||
		       (item.a_uniform && (item.a_value == 8'd0)) ||
		       (item.b_uniform && (item.b_value == 8'd0));
		last = item.last_in_block ||
		       (idx >= bsmm_pkg::IDX_W'(bsmm_pkg::ELEMS_PER_BLOCK - 1));

		addr_sum = bsmm_pkg::SUM_W'(cb) + bsmm_pkg::SUM_W'(idx);
		fits     = addr_sum < bsmm_pkg::SUM_W'(bsmm_pkg::DATA_DEPTH);
		room     = bsmm_pkg::CNT_W'(bsmm_pkg::DATA_DEPTH) - cb;
		ext      = bsmm_pkg::SUM_W'(idx) + bsmm_pkg::SUM_W'(1);
		grow     = (ext < bsmm_pkg::SUM_W'(room)) ? ext : bsmm_pkg::SUM_W'(room);
		addr32   = 32'(addr_sum);
		cb32     = 32'(cb);

		nxt.committed_bytes  = cb;
		nxt.overflow_seen    = ovf;
		nxt.all_equal_so_far = alleq;
		nxt.first_product    = first;
		nxt.element_index    = idx + bsmm_pkg::IDX_W'(1);

		res.product      = prod;
		res.data_write   = 1'b0;
		res.data_address = '0;
		res.block_done   = 1'b0;
		res.block_dense  = 1'b0;
		res.block_scalar = '0;
		res.block_start  = '0;

		if (!skip) begin
			if (idx == '0) begin
				nxt.first_product    = prod;
				nxt.all_equal_so_far = 1'b1;
			end else if (prod != first) begin
				nxt.all_equal_so_far = 1'b0;
			end
			if (fits) begin
				res.data_write   = 1'b1;
				res.data_address = addr32[19:0];
			end else begin
				nxt.overflow_seen = 1'b1;
			end
		end

		if (last) begin
			res.block_done = 1'b1;
			if (skip) begin
				res.block_scalar = (item.a_uniform && item.b_uniform) ? prod : 8'd0;
			end else if (nxt.all_equal_so_far) begin
				res.block_scalar = nxt.first_product;
			end else begin
				res.block_dense     = 1'b1;
				res.block_start     = cb32[19:0];
				nxt.committed_bytes = cb + bsmm_pkg::CNT_W'(grow);
			end
			nxt.element_index    = '0;
			nxt.all_equal_so_far = 1'b1;
			nxt.first_product    = 8'd0;
		end

		tot32          = 32'(nxt.committed_bytes);
		res.data_total = tot32[20:0];
		res.data_full  = nxt.overflow_seen;
	end

endmodule

// File: sv/block_sparse_mask_multiplier.sv
// Top level of the block-sparse mask multiplier: input register, datapath, result register.
// Depends on bsmm_pkg, bsmm_in_if, bsmm_out_if and bsmm_calc.
//
//   channel | dir | handshake         | payload
//   elem    | in  | valid/ready       | bsmm_in_t, one mask element
//   res     | out | valid/ready       | bsmm_out_t, one result per element
//
// One item per cycle sustained while the result side is ready; each accepted item passes
// the input register and then the result register. The datapath between the input and
// result registers is one 8x8 multiply with a constant divide, plus one 22-bit add and
// compare for the data address. Reset clears valids and the block state. A stalled result
// holds in its register while the input register still accepts one more item.
module block_sparse_mask_multiplier (
	input logic       clk,
	input logic       arst_n,
	bsmm_in_if.sink   elem,
	bsmm_out_if.source res
);

	bsmm_pkg::bsmm_in_t    item_s1;
	logic                  valid_s1;
	bsmm_pkg::bsmm_out_t   out_s2;
	logic                  valid_s2;
	bsmm_pkg::bsmm_state_t state_q;
	bsmm_pkg::bsmm_out_t   calc_res;
	bsmm_pkg::bsmm_state_t calc_nxt;
	logic                  adv;

	bsmm_calc u_calc (
		.item (item_s1),
		.cur  (state_q),
		.res  (calc_res),
		.nxt  (calc_nxt)
	);

	assign adv        = valid_s1 && (!valid_s2 || res.ready);
	assign elem.ready = !valid_s1 || adv;
	assign res.valid  = valid_s2;
	assign res.data   = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{committed_bytes: '0, element_index: '0, all_equal_so_far: 1'b1,
			              first_product: 8'd0, overflow_seen: 1'b0};
		end else begin
			if (elem.valid && elem.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				state_q  <= calc_nxt;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (elem.valid && elem.ready) begin
			item_s1 <= elem.data;
		end
		if (adv) begin
			out_s2 <= calc_res;
		end
	end

endmodule

// File: sv/bsmm_checker.sv
// Port-level checks on the result channel of the block-sparse mask multiplier.
// Depends on bsmm_pkg; bound to block_sparse_mask_multiplier below.
module bsmm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input bsmm_pkg::bsmm_out_t res_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result item changed while stalled");

	a_no_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.data_write |-> res_data.data_address == 20'd0)
		else $error("address without data write");

	a_descr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.block_done |->
			!res_data.block_dense && res_data.block_scalar == 8'd0 &&
			res_data.block_start == 20'd0)
		else $error("descriptor set without block end");

	a_dense_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.block_dense |-> res_data.block_scalar == 8'd0)
		else $error("dense block carries a scalar");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.data_total <= 21'(bsmm_pkg::DATA_DEPTH))
		else $error("data total beyond data area");

endmodule

bind block_sparse_mask_multiplier bsmm_checker u_bsmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

// File: tb/tb_block_sparse_mask_multiplier.sv
// Self-checking testbench for block_sparse_mask_multiplier: drives mask elements, predicts
// every result with its own model of the block state and checks each field in order.
// Depends on bsmm_pkg, bsmm_in_if, bsmm_out_if and the block itself.
module tb_block_sparse_mask_multiplier;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int unsigned {
		SHAPE_DENSE,
		SHAPE_A_UNIFORM,
		SHAPE_B_UNIFORM,
		SHAPE_BOTH_UNIFORM,
		SHAPE_EQUAL,
		SHAPE_NOISE
	} block_shape_t;

	class mask_product_tracker;
		bsmm_pkg::bsmm_out_t awaited[$];
		int unsigned committed;
		int unsigned elem_idx;
		bit          all_equal;
		logic [7:0]  first_prod;
		bit          overflow;
		int          errors;

		function new();
			errors = 0;
			clear_mask();
		endfunction

		function void clear_block();
			elem_idx = 0;
			all_equal = 1'b1;
			first_prod = 8'd0;
		endfunction

		function void clear_mask();
			committed = 0;
			overflow = 1'b0;
			clear_block();
		endfunction

		function void note_element(bsmm_pkg::bsmm_in_t it);
			bsmm_pkg::bsmm_out_t r;
			int unsigned prod;
			int unsigned addr;
			int unsigned room;
			int unsigned span;
			int unsigned idx;
			bit          skip;
			bit          closing;
			if (it.first_of_mask) begin
				clear_mask();
			end
			prod = (32'(it.a_value) * 32'(it.b_value) + 32'd127) / 32'd255;
			r = '0;
			r.product = prod[7:0];
			skip = (it.a_uniform && it.b_uniform) || (it.a_uniform && it.a_value == 8'd0) ||
				(it.b_uniform && it.b_value == 8'd0);
			idx = elem_idx;
			closing = it.last_in_block || idx >= bsmm_pkg::ELEMS_PER_BLOCK - 1;
			if (!skip) begin
				addr = committed + idx;
				if (idx == 0) begin
					first_prod = prod[7:0];
					all_equal = 1'b1;
				end else if (prod[7:0] != first_prod) begin
					all_equal = 1'b0;
				end
				if (addr < bsmm_pkg::DATA_DEPTH) begin
					r.data_write = 1'b1;
					r.data_address = addr[19:0];
				end else begin
					overflow = 1'b1;
				end
			end
			if (closing) begin
				r.block_done = 1'b1;
				if (skip) begin
					r.block_scalar = (it.a_uniform && it.b_uniform) ? prod[7:0] : 8'd0;
				end else if (all_equal) begin
					r.block_scalar = first_prod;
				end else begin
					r.block_dense = 1'b1;
					r.block_start = committed[19:0];
					room = bsmm_pkg::DATA_DEPTH - committed;
					span = idx + 1;
					committed += (span < room) ? span : room;
				end
				clear_block();
			end else begin
				elem_idx = idx + 1;
			end
			r.data_total = committed[20:0];
			r.data_full = overflow;
			awaited.push_back(r);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(bsmm_pkg::bsmm_out_t got);
			bsmm_pkg::bsmm_out_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with none pending, expected none, actual %h", $time, got);
				return;
			end
			want = awaited.pop_front();
			field_check("product", 32'(want.product), 32'(got.product));
			field_check("data_write", 32'(want.data_write), 32'(got.data_write));
			field_check("data_address", 32'(want.data_address), 32'(got.data_address));
			field_check("block_done", 32'(want.block_done), 32'(got.block_done));
			field_check("block_dense", 32'(want.block_dense), 32'(got.block_dense));
			field_check("block_scalar", 32'(want.block_scalar), 32'(got.block_scalar));
			field_check("block_start", 32'(want.block_start), 32'(got.block_start));
			field_check("data_total", 32'(want.data_total), 32'(got.data_total));
			field_check("data_full", 32'(want.data_full), 32'(got.data_full));
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bsmm_in_if  elem_ch();
	bsmm_out_if res_ch();

	mask_product_tracker tracker;
	bit                  rx_stall_enable;
	bit                  hold_request;
	int unsigned         sent_count;

	block_sparse_mask_multiplier DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			tracker.check_result(res_ch.data);
		end
	end

	initial begin
		#60000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_stall_enable && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	function automatic bsmm_pkg::bsmm_in_t make_elem(bit fm, bit au, logic [7:0] av, bit bu,
		logic [7:0] bv, bit lib);
		bsmm_pkg::bsmm_in_t it;
		it.first_of_mask = fm;
		it.a_uniform = au;
		it.a_value = av;
		it.b_uniform = bu;
		it.b_value = bv;
		it.last_in_block = lib;
		return it;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_elem(bsmm_pkg::bsmm_in_t it);
		elem_ch.valid <= 1'b1;
		elem_ch.data <= it;
		do @(posedge clk); while (elem_ch.ready !== 1'b1);
		tracker.note_element(it);
		sent_count++;
	endtask

	task automatic pause_input(int unsigned cycles);
		elem_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic await_results();
		elem_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic random_block(bit quiet);
		block_shape_t shape;
		int unsigned  r;
		int unsigned  len;
		bit           au;
		bit           bu;
		bit           fm;
		bit           flip_last;
		logic [7:0]   ca;
		logic [7:0]   cb;
		bsmm_pkg::bsmm_in_t it;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			shape = SHAPE_DENSE;
		end else if (r < 55) begin
			shape = SHAPE_A_UNIFORM;
		end else if (r < 70) begin
			shape = SHAPE_B_UNIFORM;
		end else if (r < 78) begin
			shape = SHAPE_BOTH_UNIFORM;
		end else if (r < 90) begin
			shape = SHAPE_EQUAL;
		end else begin
			shape = SHAPE_NOISE;
		end
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
		au = (shape == SHAPE_A_UNIFORM || shape == SHAPE_BOTH_UNIFORM);
		bu = (shape == SHAPE_B_UNIFORM || shape == SHAPE_BOTH_UNIFORM);
		fm = ($urandom_range(0, 7) == 0);
		flip_last = ($urandom_range(0, 19) == 0);
		ca = pick_byte();
		cb = pick_byte();
		for (int unsigned i = 0; i < len; i++) begin
			case (shape)
				SHAPE_NOISE: begin
					it = make_elem($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)),
						pick_byte(), 1'($urandom_range(0, 1)), pick_byte(),
						$urandom_range(0, 3) == 0);
				end
				SHAPE_EQUAL: begin
					// swapped operands give the same product
					it = make_elem(i == 0 && fm, 1'b0, i[0] ? cb : ca, 1'b0, i[0] ? ca : cb,
						i == len - 1);
				end
				default: begin
					it = make_elem(i == 0 && fm, au, au ? ca : pick_byte(), bu,
						bu ? cb : pick_byte(), i == len - 1);
					if (flip_last && i == len - 1) begin
						it.a_uniform = ~au;
					end
				end
			endcase
			if (!quiet && $urandom_range(0, 5) == 0) begin
				pause_input($urandom_range(1, 17));
			end
			send_elem(it);
		end
	endtask

	task automatic dense_run(int unsigned len, bit fm, bit mark_last);
		logic [7:0] av;
		logic [7:0] bv;
		for (int unsigned i = 0; i < len; i++) begin
			if (i == 0) begin
				av = 8'd0;
				bv = 8'd0;
			end else if (i == 1) begin
				av = 8'd255;
				bv = 8'd255;
			end else begin
				av = 8'($urandom_range(0, 255));
				bv = 8'($urandom_range(0, 255));
			end
			send_elem(make_elem(fm && i == 0, 1'b0, av, 1'b0, bv, mark_last && i == len - 1));
		end
	endtask

	initial begin
		bsmm_pkg::bsmm_in_t opening[$];
		bit          quiet;
		bit          hold_done;
		bit          drain_done;
		int unsigned target;
		tracker = new();
		rx_stall_enable = 1'b1;
		hold_request = 1'b0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		sent_count = 0;
		arst_n <= 1'b0;
		elem_ch.valid <= 1'b0;
		elem_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		opening.push_back(make_elem(1'b1, 1'b0, 8'd255, 1'b0, 8'd255, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd255, 1'b0, 8'd255, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd1, 1'b0, 8'd128, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd200, 1'b1, 8'd100, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd0, 1'b0, 8'd77, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd0, 1'b0, 8'd255, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd255, 1'b1, 8'd0, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd255, 1'b0, 8'd10, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd255, 1'b0, 8'd20, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd255, 1'b0, 8'd255, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd255, 1'b0, 8'd100, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd100, 1'b0, 8'd255, 1'b1));
		// skipped first element, so no first product is recorded
		opening.push_back(make_elem(1'b0, 1'b1, 8'd5, 1'b1, 8'd6, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd9, 1'b0, 8'd200, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd50, 1'b0, 8'd60, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd255, 1'b1, 8'd255, 1'b1));
		// new mask in the middle of a block
		opening.push_back(make_elem(1'b0, 1'b0, 8'd3, 1'b0, 8'd4, 1'b0));
		opening.push_back(make_elem(1'b1, 1'b0, 8'd7, 1'b0, 8'd8, 1'b0));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd255, 1'b0, 8'd0, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b1, 8'd255, 1'b1, 8'd0, 1'b1));
		opening.push_back(make_elem(1'b0, 1'b0, 8'd128, 1'b0, 8'd128, 1'b1));
		foreach (opening[i]) begin
			if ($urandom_range(0, 2) == 0) begin
				pause_input($urandom_range(1, 17));
			end
			send_elem(opening[i]);
		end
		await_results();

		target = sent_count + 1650;
		while (sent_count < target) begin
			quiet = ($urandom_range(0, 2) == 0);
			if (!hold_done && sent_count > target - 1000) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
				quiet = 1'b1;
			end
			if (!drain_done && sent_count > target - 500) begin
				await_results();
				drain_done = 1'b1;
			end
			random_block(quiet);
		end
		await_results();

		// tail at full rate, no idling on either side
		rx_stall_enable = 1'b0;
		dense_run(20, 1'b0, 1'b1);
		dense_run(5, 1'b0, 1'b1);
		send_elem(make_elem(1'b0, 1'b0, 8'd200, 1'b0, 8'd200, 1'b0));
		send_elem(make_elem(1'b0, 1'b0, 8'd200, 1'b0, 8'd200, 1'b1));
		send_elem(make_elem(1'b0, 1'b1, 8'd9, 1'b1, 8'd9, 1'b1));
		dense_run(4, 1'b1, 1'b1);
		await_results();
		repeat (20) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (tracker.pending() != 0) begin
				$display("%0t: %0d results never arrived", $time, tracker.pending());
			end
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
